// ----- hw/rtl/detection_decode_centroid_tracker_macros.svh -----
// Assertion macros used by the tracker back module.
`ifndef DETECTION_DECODE_CENTROID_TRACKER_MACROS_SVH
`define DETECTION_DECODE_CENTROID_TRACKER_MACROS_SVH

// Check a consequent in the same cycle as its antecedent.
`define DDCT_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check a consequent in the cycle after its antecedent.
`define DDCT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hw/rtl/ddct_pkg.sv -----
// Package: shared types and constants of the centroid tracker.
package ddct_pkg;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam int DEPTH_W    = 22;
    localparam int DIV_NUM_W  = 42;

    localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SCALE_X   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SCALE_Y   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ALPHA     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_FOCAL_X   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_FOCAL_Y   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_W   = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_H   = 3'd7;

    localparam logic [21:0] CAM_TERM_MM = 22'd40;
    localparam logic [16:0] EMA_ONE     = 17'd65536;
    localparam logic [37:0] EMA_ROUND   = 38'd32768;

    typedef struct packed {
        logic [15:0] score_threshold;
        logic [15:0] scale_x;
        logic [15:0] scale_y;
        logic [15:0] filter_alpha;
        logic [15:0] focal_x;
        logic [15:0] focal_y;
        logic [11:0] image_width;
        logic [11:0] image_height;
    } cfg_t;

endpackage

// ----- hw/rtl/ddct_if.sv -----
// Interfaces: anchor and result channels.
interface ddct_anchor_if #(
    parameter int COORD_BITS = 16,
    parameter int SCORE_BITS = 16
);
    logic                  valid;
    logic                  ready;
    logic [COORD_BITS-1:0] anchor_cx;
    logic [COORD_BITS-1:0] anchor_cy;
    logic [COORD_BITS-1:0] anchor_w;
    logic [COORD_BITS-1:0] anchor_h;
    logic [SCORE_BITS-1:0] anchor_score;
    logic                  last_anchor;
    logic signed [20:0]    vehicle_height;
    logic signed [20:0]    pad_height;

    modport source (
        output valid, anchor_cx, anchor_cy, anchor_w, anchor_h, anchor_score,
               last_anchor, vehicle_height, pad_height,
        input  ready
    );
    modport sink (
        input  valid, anchor_cx, anchor_cy, anchor_w, anchor_h, anchor_score,
               last_anchor, vehicle_height, pad_height,
        output ready
    );
endinterface

interface ddct_result_if;
    logic               valid;
    logic               ready;
    logic               target_found;
    logic [19:0]        centroid_x;
    logic [19:0]        centroid_y;
    logic signed [19:0] pixel_offset_x;
    logic signed [19:0] pixel_offset_y;
    logic signed [23:0] lateral_x;
    logic signed [23:0] lateral_y;

    modport source (
        output valid, target_found, centroid_x, centroid_y, pixel_offset_x,
               pixel_offset_y, lateral_x, lateral_y,
        input  ready
    );
    modport sink (
        input  valid, target_found, centroid_x, centroid_y, pixel_offset_x,
               pixel_offset_y, lateral_x, lateral_y,
        output ready
    );
endinterface

// ----- hw/rtl/ddct_fifo.sv -----
// Two-entry job queue between the front and the back.
module ddct_fifo #(
    parameter int W = 8
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         push,
    input  logic [W-1:0] push_data,
    output logic         full,
    input  logic         pop,
    output logic         not_empty,
    output logic [W-1:0] pop_data
);
    logic [W-1:0] mem_reg [2];
    logic         wr_ptr_reg;
    logic         rd_ptr_reg;
    logic [1:0]   count_reg;

    assign full      = (count_reg == 2'd2);
    assign not_empty = (count_reg != 2'd0);
    assign pop_data  = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 2'd1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 2'd1;
            end
        end
    end
endmodule

// ----- hw/rtl/ddct_front.sv -----
// Front: anchor intake and best-anchor selection, emits one job per frame.
module ddct_front #(
    parameter int COORD_BITS = 16,
    parameter int SCORE_BITS = 16,
    parameter int JOB_W      = 1 + 4 * COORD_BITS + ddct_pkg::DEPTH_W
) (
    input  logic              clk,
    input  logic              rst_n,
    ddct_anchor_if.sink       anchors,
    input  logic [15:0]       score_threshold,
    input  logic              queue_full,
    output logic              job_push,
    output logic [JOB_W-1:0]  job_data
);
    logic                      best_valid_reg;
    logic [SCORE_BITS-1:0]     best_score_reg;
    logic [4*COORD_BITS-1:0]   best_box_reg;
    logic [SCORE_BITS+15:0]    thr_wide;
    logic [SCORE_BITS-1:0]     thr_eff;
    logic                      accept;
    logic                      take;
    logic [4*COORD_BITS-1:0]   box_in;
    logic [4*COORD_BITS-1:0]   box_next;
    logic signed [ddct_pkg::DEPTH_W-1:0] depth_next;

    assign anchors.ready = !queue_full;
    assign accept        = anchors.valid && anchors.ready;

    assign thr_wide = {{SCORE_BITS{1'b0}}, score_threshold};
    assign thr_eff  = thr_wide[SCORE_BITS-1:0];
    assign take     = (anchors.anchor_score > thr_eff)
                   && (!best_valid_reg || anchors.anchor_score > best_score_reg);

    assign box_in   = {anchors.anchor_cx, anchors.anchor_cy, anchors.anchor_w, anchors.anchor_h};
    assign box_next = take ? box_in : best_box_reg;

    assign depth_next = ddct_pkg::DEPTH_W'(anchors.vehicle_height)
                      - ddct_pkg::DEPTH_W'(anchors.pad_height);

    assign job_push = accept && anchors.last_anchor;
    assign job_data = {best_valid_reg || take, box_next, depth_next};

    always_ff @(posedge clk)
    begin
        if (accept && take)
        begin
            best_box_reg <= box_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            best_valid_reg <= 1'b0;
            best_score_reg <= '0;
        end
        else if (accept)
        begin
            if (anchors.last_anchor)
            begin
                best_valid_reg <= 1'b0;
                best_score_reg <= '0;
            end
            else if (take)
            begin
                best_valid_reg <= 1'b1;
                best_score_reg <= anchors.anchor_score;
            end
        end
    end
endmodule

// ----- hw/rtl/ddct_div.sv -----
// Radix-2 restoring divider, one quotient bit per cycle.
module ddct_div #(
    parameter int NW = 42,
    parameter int DW = 22
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic [NW-1:0] dividend,
    input  logic [DW-1:0] divisor,
    output logic          busy,
    output logic          done,
    output logic [NW-1:0] quotient
);
    localparam int CW = $clog2(NW + 1);

    logic [DW-1:0] rem_reg;
    logic [DW-1:0] div_reg;
    logic [NW-1:0] quot_reg;
    logic [CW-1:0] cnt_reg;
    logic          busy_reg;
    logic          done_reg;
    logic [DW:0]   trial;
    logic          fits;

    assign trial    = {rem_reg, quot_reg[NW-1]};
    assign fits     = (trial >= {1'b0, div_reg});
    assign busy     = busy_reg;
    assign done     = done_reg;
    assign quotient = quot_reg;

    always_ff @(posedge clk)
    begin
        if (start && !busy_reg)
        begin
            rem_reg  <= '0;
            div_reg  <= divisor;
            quot_reg <= dividend;
        end
        else if (busy_reg)
        begin
            rem_reg  <= fits ? DW'(trial - {1'b0, div_reg}) : trial[DW-1:0];
            quot_reg <= {quot_reg[NW-2:0], fits};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start && !busy_reg)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + CW'(1);
                if (cnt_reg == CW'(NW - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end
endmodule

// ----- hw/rtl/ddct_back.sv -----
// Back: box decode, smoothing, centre correction and lateral distance.
`include "detection_decode_centroid_tracker_macros.svh"

module ddct_back #(
    parameter int COORD_BITS = 16,
    parameter int JOB_W      = 1 + 4 * COORD_BITS + ddct_pkg::DEPTH_W
) (
    input  logic             clk,
    input  logic             rst_n,
    input  ddct_pkg::cfg_t   cfg,
    input  logic             job_valid,
    input  logic [JOB_W-1:0] job_data,
    output logic             job_pop,
    ddct_result_if.source    results
);
    localparam int C   = COORD_BITS;
    localparam int PW  = C + 19;
    localparam int SW  = C + 16;
    localparam int DTW = PW + 4;
    localparam int NW  = ddct_pkg::DIV_NUM_W;
    localparam int DW  = ddct_pkg::DEPTH_W;
    localparam logic signed [PW-1:0] LEFT_RND = PW'((1 << 20) - 1);

    typedef enum logic [10:0] {
        ST_IDLE  = 11'b00000000001,
        ST_DEC   = 11'b00000000010,
        ST_DET   = 11'b00000000100,
        ST_EMA   = 11'b00000001000,
        ST_FILT  = 11'b00000010000,
        ST_CDIV  = 11'b00000100000,
        ST_OFFS  = 11'b00001000000,
        ST_LMUL  = 11'b00010000000,
        ST_LXDIV = 11'b00100000000,
        ST_LYDIV = 11'b01000000000,
        ST_OUT   = 11'b10000000000
    } state_t;

    state_t state_reg;

    logic                 job_found_reg;
    logic [C-1:0]         box_cx_reg, box_cy_reg, box_w_reg, box_h_reg;
    logic signed [DW-1:0] depth_reg;
    logic                 depth_pos;

    logic signed [PW-1:0] p_x_reg, p_y_reg;
    logic [SW-1:0]        wd_x_reg, wd_y_reg;
    logic [19:0]          det_x_reg, det_y_reg;
    logic [35:0]          pa_x_reg, pa_y_reg;
    logic [36:0]          pb_x_reg, pb_y_reg;
    logic [19:0]          filt_x_reg, filt_y_reg;
    logic                 first_pending_reg;
    logic [21:0]          q_reg;
    logic signed [19:0]   off_x_reg, off_y_reg;
    logic                 neg_x_reg, neg_y_reg;
    logic [NW-1:0]        mag_y_reg;
    logic signed [23:0]   lat_x_reg, lat_y_reg;

    logic                 out_valid_reg;
    logic                 out_found_reg;
    logic [19:0]          out_cx_reg, out_cy_reg;
    logic signed [19:0]   out_ox_reg, out_oy_reg;
    logic signed [23:0]   out_lx_reg, out_ly_reg;

    logic                 div_start;
    logic [NW-1:0]        div_num;
    logic [DW-1:0]        div_den;
    logic                 div_busy;
    logic                 div_done;
    logic [NW-1:0]        div_quot;

    logic [15:0]          fx_eff, fy_eff;
    logic [19:0]          det_x_next, det_y_next;
    logic [19:0]          filt_x_next, filt_y_next;
    logic signed [19:0]   off_x_next, off_y_next;
    logic signed [23:0]   lat_next;
    logic                 out_free;

    function automatic logic signed [PW-1:0] axis_p(
        input logic [C-1:0]  c,
        input logic [C-1:0]  s,
        input logic [15:0]   sc
    );
        logic signed [C+1:0] d;
        d = $signed({1'b0, c, 1'b0}) - $signed({2'b00, s});
        return PW'(d) * PW'($signed({1'b0, sc}));
    endfunction

    function automatic logic [19:0] axis_det(
        input logic signed [PW-1:0] p,
        input logic [SW-1:0]        wd
    );
        logic signed [PW-1:0]  lft;
        logic signed [DTW-1:0] raw;
        lft = (p < 0) ? ((p + LEFT_RND) >>> 20) : (p >>> 20);
        raw = ((DTW'(lft) <<< 1) + $signed({{(DTW-SW){1'b0}}, wd})) <<< 3;
        if (raw < 0)
        begin
            return 20'd0;
        end
        else if (raw > $signed(DTW'(20'hFFFFF)))
        begin
            return 20'hFFFFF;
        end
        return raw[19:0];
    endfunction

    function automatic logic [19:0] ema(
        input logic [35:0] pa,
        input logic [36:0] pb
    );
        logic [37:0] acc;
        acc = 38'(pa) + 38'(pb) + ddct_pkg::EMA_ROUND;
        return acc[35:16];
    endfunction

    function automatic logic signed [19:0] offset(
        input logic [19:0]  filt,
        input logic [14:0]  cen8,
        input logic [21:0]  q
    );
        logic signed [23:0] cen;
        logic signed [23:0] diff;
        cen  = $signed({9'b0, cen8}) - $signed({2'b0, q});
        diff = $signed({4'b0, filt}) - cen;
        if (diff < -24'sd524288)
        begin
            return -20'sd524288;
        end
        else if (diff > 24'sd524287)
        begin
            return 20'sd524287;
        end
        return diff[19:0];
    endfunction

    function automatic logic signed [23:0] lat_sat(
        input logic          neg,
        input logic [NW-1:0] q
    );
        if (!neg)
        begin
            return (q > NW'(24'h7FFFFF)) ? 24'sh7FFFFF : $signed(q[23:0]);
        end
        return (q > NW'(24'h800000)) ? 24'sh800000 : -$signed(q[23:0]);
    endfunction

    assign depth_pos = (depth_reg > 0);
    assign fx_eff    = (cfg.focal_x == 16'd0) ? 16'd1 : cfg.focal_x;
    assign fy_eff    = (cfg.focal_y == 16'd0) ? 16'd1 : cfg.focal_y;
    assign out_free  = !out_valid_reg || results.ready;
    assign job_pop   = (state_reg == ST_IDLE) && job_valid;

    assign det_x_next  = axis_det(p_x_reg, wd_x_reg);
    assign det_y_next  = axis_det(p_y_reg, wd_y_reg);
    assign filt_x_next = first_pending_reg ? det_x_reg : ema(pa_x_reg, pb_x_reg);
    assign filt_y_next = first_pending_reg ? det_y_reg : ema(pa_y_reg, pb_y_reg);
    assign off_x_next  = offset(filt_x_reg, {cfg.image_width, 3'b000}, 22'd0);
    assign off_y_next  = offset(filt_y_reg, {cfg.image_height, 3'b000}, q_reg);
    assign lat_next    = lat_sat((state_reg == ST_LXDIV) ? neg_x_reg : neg_y_reg, div_quot);

    always_comb
    begin
        div_start = 1'b0;
        div_num   = '0;
        div_den   = '0;
        unique case (state_reg)
            ST_FILT:
            begin
                div_start = depth_pos;
                div_num   = NW'(cfg.focal_y * ddct_pkg::CAM_TERM_MM);
                div_den   = depth_reg;
            end
            ST_LMUL:
            begin
                div_start = depth_pos;
                div_num   = (off_x_reg < 0) ? NW'(-(NW'(off_x_reg) * NW'(depth_reg)))
                                            : NW'(NW'(off_x_reg) * NW'(depth_reg));
                div_den   = DW'(fx_eff);
            end
            ST_LXDIV:
            begin
                div_start = div_done;
                div_num   = mag_y_reg;
                div_den   = DW'(fy_eff);
            end
            ST_IDLE, ST_DEC, ST_DET, ST_EMA, ST_CDIV, ST_OFFS, ST_LYDIV, ST_OUT:
            begin
                div_start = 1'b0;
            end
            default:
            begin
                div_start = 1'b0;
            end
        endcase
    end

    ddct_div #(
        .NW (NW),
        .DW (DW)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_num),
        .divisor  (div_den),
        .busy     (div_busy),
        .done     (div_done),
        .quotient (div_quot)
    );

    always_ff @(posedge clk)
    begin
        if (job_pop)
        begin
            {job_found_reg, box_cx_reg, box_cy_reg, box_w_reg, box_h_reg, depth_reg} <= job_data;
        end
        if (state_reg == ST_DEC)
        begin
            p_x_reg  <= axis_p(box_cx_reg, box_w_reg, cfg.scale_x);
            p_y_reg  <= axis_p(box_cy_reg, box_h_reg, cfg.scale_y);
            wd_x_reg <= SW'((SW'(box_w_reg) * SW'(cfg.scale_x)) >> 19);
            wd_y_reg <= SW'((SW'(box_h_reg) * SW'(cfg.scale_y)) >> 19);
        end
        if (state_reg == ST_DET)
        begin
            det_x_reg <= det_x_next;
            det_y_reg <= det_y_next;
        end
        if (state_reg == ST_EMA)
        begin
            pa_x_reg <= 36'(cfg.filter_alpha) * 36'(det_x_reg);
            pa_y_reg <= 36'(cfg.filter_alpha) * 36'(det_y_reg);
            pb_x_reg <= 37'(ddct_pkg::EMA_ONE - 17'(cfg.filter_alpha)) * 37'(filt_x_reg);
            pb_y_reg <= 37'(ddct_pkg::EMA_ONE - 17'(cfg.filter_alpha)) * 37'(filt_y_reg);
        end
        if (state_reg == ST_FILT)
        begin
            q_reg <= '0;
        end
        if (state_reg == ST_CDIV && div_done)
        begin
            q_reg <= div_quot[21:0];
        end
        if (state_reg == ST_LMUL)
        begin
            neg_x_reg <= (off_x_reg < 0);
            neg_y_reg <= (off_y_reg < 0);
            mag_y_reg <= (off_y_reg < 0) ? NW'(-(NW'(off_y_reg) * NW'(depth_reg)))
                                         : NW'(NW'(off_y_reg) * NW'(depth_reg));
            lat_x_reg <= '0;
            lat_y_reg <= '0;
        end
        if (state_reg == ST_LXDIV && div_done)
        begin
            lat_x_reg <= lat_next;
        end
        if (state_reg == ST_LYDIV && div_done)
        begin
            lat_y_reg <= lat_next;
        end
        if (state_reg == ST_OUT && out_free)
        begin
            out_found_reg <= job_found_reg;
            out_cx_reg    <= filt_x_reg;
            out_cy_reg    <= filt_y_reg;
            out_ox_reg    <= off_x_reg;
            out_oy_reg    <= off_y_reg;
            out_lx_reg    <= lat_x_reg;
            out_ly_reg    <= lat_y_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= ST_IDLE;
            first_pending_reg <= 1'b1;
            filt_x_reg        <= '0;
            filt_y_reg        <= '0;
            off_x_reg         <= '0;
            off_y_reg         <= '0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            if (state_reg == ST_OUT && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (results.ready)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (job_valid)
                    begin
                        state_reg <= job_data[JOB_W-1] ? ST_DEC : ST_LMUL;
                    end
                end
                ST_DEC:
                begin
                    state_reg <= ST_DET;
                end
                ST_DET:
                begin
                    state_reg <= ST_EMA;
                end
                ST_EMA:
                begin
                    state_reg <= ST_FILT;
                end
                ST_FILT:
                begin
                    filt_x_reg        <= filt_x_next;
                    filt_y_reg        <= filt_y_next;
                    first_pending_reg <= 1'b0;
                    state_reg         <= depth_pos ? ST_CDIV : ST_OFFS;
                end
                ST_CDIV:
                begin
                    if (div_done)
                    begin
                        state_reg <= ST_OFFS;
                    end
                end
                ST_OFFS:
                begin
                    off_x_reg <= off_x_next;
                    off_y_reg <= off_y_next;
                    state_reg <= ST_LMUL;
                end
                ST_LMUL:
                begin
                    state_reg <= depth_pos ? ST_LXDIV : ST_OUT;
                end
                ST_LXDIV:
                begin
                    if (div_done)
                    begin
                        state_reg <= ST_LYDIV;
                    end
                end
                ST_LYDIV:
                begin
                    if (div_done)
                    begin
                        state_reg <= ST_OUT;
                    end
                end
                ST_OUT:
                begin
                    if (out_free)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign results.valid          = out_valid_reg;
    assign results.target_found   = out_found_reg;
    assign results.centroid_x     = out_cx_reg;
    assign results.centroid_y     = out_cy_reg;
    assign results.pixel_offset_x = out_ox_reg;
    assign results.pixel_offset_y = out_oy_reg;
    assign results.lateral_x      = out_lx_reg;
    assign results.lateral_y      = out_ly_reg;

    `DDCT_ASSERT_NOW(a_pop_in_idle, clk, rst_n, job_pop, state_reg == ST_IDLE, "job taken while busy")
    `DDCT_ASSERT_NEXT(a_first_cleared, clk, rst_n, state_reg == ST_FILT, !first_pending_reg, "first detection flag kept")
    `DDCT_ASSERT_NOW(a_lat_zero, clk, rst_n, state_reg == ST_OUT && !depth_pos, lat_x_reg == 24'sd0 && lat_y_reg == 24'sd0, "lateral not zero at non-positive depth")
    `DDCT_ASSERT_NOW(a_div_start_idle, clk, rst_n, div_start, !div_busy, "divider started while busy")
endmodule

// ----- hw/rtl/detection_decode_centroid_tracker.sv -----
// Top level: configuration registers, anchor front, job queue and result back.
// Anchors are taken one per cycle while the job queue has room; only a frame end gives a result.
// A result follows each frame end, after the divider runs that the job needs: three with a target and
// positive depth, two without a target, none when depth is not positive.
// The back takes the next job only when it is done with the last; a two-job queue lets anchors flow meanwhile.
// Reset: asynchronous, active low; registers take their defaults, state and queue clear.
module detection_decode_centroid_tracker #(
    parameter int COORD_BITS = 16,
    parameter int SCORE_BITS = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [ddct_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [ddct_pkg::CFG_DATA_W-1:0]     cfg_data,
    ddct_anchor_if.sink                         anchors,
    ddct_result_if.source                       results
);
    localparam int JOB_W = 1 + 4 * COORD_BITS + ddct_pkg::DEPTH_W;

    ddct_pkg::cfg_t   cfg_reg;
    logic             job_push;
    logic [JOB_W-1:0] job_in;
    logic             queue_full;
    logic             job_pop;
    logic             job_valid;
    logic [JOB_W-1:0] job_out;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.score_threshold <= 16'd32768;
            cfg_reg.scale_x         <= 16'd6302;
            cfg_reg.scale_y         <= 16'd4726;
            cfg_reg.filter_alpha    <= 16'd32768;
            cfg_reg.focal_x         <= 16'd9600;
            cfg_reg.focal_y         <= 16'd9600;
            cfg_reg.image_width     <= 12'd640;
            cfg_reg.image_height    <= 12'd480;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                ddct_pkg::REG_THRESHOLD: cfg_reg.score_threshold <= cfg_data;
                ddct_pkg::REG_SCALE_X:   cfg_reg.scale_x         <= cfg_data;
                ddct_pkg::REG_SCALE_Y:   cfg_reg.scale_y         <= cfg_data;
                ddct_pkg::REG_ALPHA:     cfg_reg.filter_alpha    <= cfg_data;
                ddct_pkg::REG_FOCAL_X:   cfg_reg.focal_x         <= cfg_data;
                ddct_pkg::REG_FOCAL_Y:   cfg_reg.focal_y         <= cfg_data;
                ddct_pkg::REG_IMAGE_W:   cfg_reg.image_width     <= cfg_data[11:0];
                ddct_pkg::REG_IMAGE_H:   cfg_reg.image_height    <= cfg_data[11:0];
                default:
                begin
                end
            endcase
        end
    end

    ddct_front #(
        .COORD_BITS (COORD_BITS),
        .SCORE_BITS (SCORE_BITS),
        .JOB_W      (JOB_W)
    ) u_front (
        .clk             (clk),
        .rst_n           (rst_n),
        .anchors         (anchors),
        .score_threshold (cfg_reg.score_threshold),
        .queue_full      (queue_full),
        .job_push        (job_push),
        .job_data        (job_in)
    );

    ddct_fifo #(
        .W (JOB_W)
    ) u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (job_push),
        .push_data (job_in),
        .full      (queue_full),
        .pop       (job_pop),
        .not_empty (job_valid),
        .pop_data  (job_out)
    );

    ddct_back #(
        .COORD_BITS (COORD_BITS),
        .JOB_W      (JOB_W)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .job_valid (job_valid),
        .job_data  (job_out),
        .job_pop   (job_pop),
        .results   (results)
    );
endmodule
